/* rtl/core/mrbm_pkg.sv */
package mrbm_pkg;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 1024;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int CNT_W = $clog2(MAX_COLS + 1);
	localparam int HGT_W = $clog2(MAX_ROWS + 1);
	localparam int AREA_W = 17;
	localparam int PROD_W = HGT_W + CNT_W;
	localparam int CFG_W = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AREA_W-1:0] AREA_LIMIT = '1;
	localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(64);

	// One classified cell as the front hands it to the back.
	typedef struct packed {
		logic             filled;
		logic [COL_W-1:0] col;
		logic             scan;
		logic             last;
	} cmd_t;

	// Stack entry: left edge of the bar's span and its height.
	typedef struct packed {
		logic [CNT_W-1:0] left;
		logic [HGT_W-1:0] hgt;
	} stk_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_UPD,
		BK_SCAN_RD,
		BK_SCAN_CMP,
		BK_POP_ACC,
		BK_FINISH
	} bk_state_t;

endpackage

/* rtl/core/mrbm_front.sv */
module mrbm_front
	import mrbm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cell_req,
	input  logic             last_cell,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             q_full,
	output logic             q_push,
	output cmd_t             q_cmd
);

	logic [CFG_W-1:0] columns_q;
	logic [COL_W-1:0] col_q;
	logic [CFG_W-1:0] cols;
	logic [CNT_W-1:0] col_next;
	logic             row_end;

	always_comb begin
		if (columns_q == '0) begin
			cols = CFG_W'(1);
		end else if (columns_q > CFG_W'(MAX_COLS)) begin
			cols = CFG_W'(MAX_COLS);
		end else begin
			cols = columns_q;
		end
	end

	assign col_next = CNT_W'(col_q) + CNT_W'(1);
	assign row_end = CFG_W'(col_next) >= cols;
	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		q_cmd.filled = cell_req;
		q_cmd.col = col_q;
		q_cmd.scan = row_end || last_cell;
		q_cmd.last = last_cell;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
		end else if (cfg_we) begin
			columns_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (q_push) begin
			if (row_end || last_cell) begin
				col_q <= '0;
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

endmodule

/* rtl/core/mrbm_queue.sv */
module mrbm_queue
	import mrbm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output cmd_t head_cmd
);

	cmd_t              entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign head_cmd = entries[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/core/mrbm_back.sv */
module mrbm_back
	import mrbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              head_cmd,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [AREA_W-1:0] max_area
);

	bk_state_t         state_q;
	bk_state_t         state_d;
	cmd_t              cmd_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  left_q;
	logic [CNT_W-1:0]  depth_q;
	stk_t              top_q;
	logic [PROD_W-1:0] prod_s;
	logic [AREA_W-1:0] best_q;
	logic [AREA_W-1:0] area_q;
	logic              out_valid_q;

	logic [HGT_W-1:0]  hmem [MAX_COLS];
	logic [MAX_COLS-1:0] hv_q;
	logic [HGT_W-1:0]  rd_h_q;
	logic              rd_v_q;
	stk_t              smem [MAX_COLS];
	stk_t              stk_rd_q;

	logic              h_rd;
	logic [COL_W-1:0]  h_rd_addr;
	logic              h_wr;
	logic              s_push;
	logic              s_pop;
	logic              fin_go;
	logic [HGT_W-1:0]  old_h;
	logic [HGT_W-1:0]  new_h;
	logic [HGT_W-1:0]  cur_h;
	logic              at_end;
	logic              pop_c;
	logic [CNT_W-1:0]  width;
	logic [CNT_W-1:0]  below_idx;
	logic [AREA_W-1:0] area;

	assign old_h = rd_v_q ? rd_h_q : '0;
	assign at_end = i_q == n_q;
	assign cur_h = at_end ? '0 : old_h;
	// Pop while the top bar is at least as tall as the current column.
	assign pop_c = (depth_q != '0) && (top_q.hgt >= cur_h);
	assign width = i_q - top_q.left;
	assign below_idx = depth_q - CNT_W'(2);
	assign area = prod_s[PROD_W-1:AREA_W] != '0 ? AREA_LIMIT : prod_s[AREA_W-1:0];

	always_comb begin
		if (!cmd_q.filled) begin
			new_h = '0;
		end else if (old_h < HGT_W'(MAX_ROWS)) begin
			new_h = old_h + HGT_W'(1);
		end else begin
			new_h = old_h;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_d = BK_UPD;
				end
			end
			BK_UPD: begin
				state_d = cmd_q.scan ? BK_SCAN_RD : BK_IDLE;
			end
			BK_SCAN_RD: begin
				state_d = BK_SCAN_CMP;
			end
			BK_SCAN_CMP: begin
				if (pop_c) begin
					state_d = BK_POP_ACC;
				end else if (!at_end) begin
					state_d = BK_SCAN_RD;
				end else begin
					state_d = cmd_q.last ? BK_FINISH : BK_IDLE;
				end
			end
			BK_POP_ACC: begin
				state_d = BK_SCAN_CMP;
			end
			BK_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		h_rd = 1'b0;
		h_rd_addr = i_q[COL_W-1:0];
		h_wr = 1'b0;
		s_push = 1'b0;
		s_pop = 1'b0;
		fin_go = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop = q_valid;
				h_rd = q_valid;
				h_rd_addr = head_cmd.col;
			end
			BK_UPD: begin
				h_wr = 1'b1;
			end
			BK_SCAN_RD: begin
				h_rd = !at_end;
			end
			BK_SCAN_CMP: begin
				s_pop = pop_c;
				s_push = !pop_c && !at_end;
			end
			BK_FINISH: begin
				fin_go = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_wr) begin
			hmem[cmd_q.col] <= new_h;
		end
		if (h_rd) begin
			rd_h_q <= hmem[h_rd_addr];
			rd_v_q <= hv_q[h_rd_addr];
		end
	end

	// Entries below the top of stack live in memory; the top stays in top_q.
	always_ff @(posedge clk) begin
		if (s_push && depth_q != '0) begin
			smem[depth_q[COL_W-1:0] - COL_W'(1)] <= top_q;
		end
		if (s_pop && depth_q > CNT_W'(1)) begin
			stk_rd_q <= smem[below_idx[COL_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= head_cmd;
		end
		if (h_wr) begin
			n_q <= CNT_W'(cmd_q.col) + CNT_W'(1);
			left_q <= '0;
		end
		if (s_pop) begin
			prod_s <= PROD_W'(top_q.hgt) * PROD_W'(width);
			left_q <= top_q.left;
		end
		if (s_push) begin
			top_q.left <= left_q;
			top_q.hgt <= cur_h;
			left_q <= i_q + CNT_W'(1);
		end
		if (state_q == BK_POP_ACC && depth_q != '0) begin
			top_q <= stk_rd_q;
		end
		if (fin_go) begin
			area_q <= best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			i_q <= '0;
			depth_q <= '0;
			best_q <= '0;
			hv_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (h_wr) begin
				hv_q[cmd_q.col] <= 1'b1;
				i_q <= '0;
				depth_q <= '0;
			end
			if (s_pop) begin
				depth_q <= depth_q - CNT_W'(1);
			end
			if (s_push) begin
				depth_q <= depth_q + CNT_W'(1);
				i_q <= i_q + CNT_W'(1);
			end
			if (state_q == BK_POP_ACC && area > best_q) begin
				best_q <= area;
			end
			if (fin_go) begin
				best_q <= '0;
				hv_q <= '0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign max_area = area_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CNT_W'(MAX_COLS))
		else $error("stack depth beyond column count");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN_RD || state_q == BK_SCAN_CMP) |-> i_q <= n_q)
		else $error("scan index passed the row length");

	a_pop_origin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_POP_ACC |-> $past(state_q) == BK_SCAN_CMP && $past(depth_q) != '0)
		else $error("pop without a stacked bar");

	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> best_q == '0 && hv_q == '0 && out_valid_q)
		else $error("matrix state not cleared on result");

	a_scan_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN_CMP && at_end && !pop_c) |-> depth_q == '0)
		else $error("row scan ended with bars on the stack");

endmodule

/* rtl/core/maximal_rectangle_binary_matrix_core.sv */
// Each request (one cell) is taken whenever the 4-entry command queue has room.
// A cell that does not end a row costs the back end a height read (BK_IDLE) and a write (BK_UPD).
// A row end adds the histogram scan: a read and a compare for each column, a compare and an
// accumulate for each stack pop, and a read and a compare to close the scan (stack walk).
// After the scan of the final cell ends, the back end enters BK_FINISH and, once any
// earlier result has been taken, registers the result and raises out_valid.
// Reset is asynchronous: heights read as zero at once, columns returns to 64, no clear pass.
module maximal_rectangle_binary_matrix_core
	import mrbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cell_req,
	input  logic              last_cell,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [AREA_W-1:0] max_area,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t head_cmd;

	mrbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cell_req  (cell_req),
		.last_cell (last_cell),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	mrbm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.head_cmd (head_cmd)
	);

	mrbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head_cmd  (head_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.max_area  (max_area)
	);

endmodule
